/* sv/qebp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qebp_pkg;

    // Fixed field widths
    localparam int PIN_W  = 5;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int BTN_W  = 15;
    localparam int AB_W   = 2;
    localparam int LANE_BTNS = 3;

    localparam int ENCODERS_DEF = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'd1;

    localparam logic [CFG_W-1:0] PULSE_LEN_RST = 16'd20;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd8;
    localparam logic [AB_W-1:0]  AB_IDLE       = 2'd3;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_CW   = 2'b01,
        DIR_CCW  = 2'b10
    } t_dir;

    // Indexed by {previous AB, current AB}
    localparam t_dir STEP_TABLE [16] = '{
        DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE,
        DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
        DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
        DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE
    };

    typedef struct packed {
        logic [CFG_W-1:0] pulse_len;
        logic [CFG_W-1:0] debounce;
    } t_cfg;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic sw;
    } t_lane_in;

endpackage

`default_nettype wire

/* sv/quadrature_encoder_button_pulser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Quadrature decoder with switch debounce, presented as a button vector.
// Each input transaction carries one sample of the A, B and switch pins of
// every encoder plus a free-running millisecond timestamp; each yields exactly
// one output transaction, the 15-bit vector with CW at bit 3i, CCW at bit 3i+1
// and the debounced switch at bit 3i+2. One lane per encoder decodes the step,
// times its two rotation pulses and debounces its switch; all lanes run in
// the same cycle and an output stage merges them. Throughput is one
// transaction per clock unless the output stalls; results are registered in
// the output stage, which holds two, so o_in_ready drops only when two results
// wait. A rotation button stays raised until now_ms reaches now + pulse_len_ms
// (a deadline that wraps to zero never releases). Write configuration only
// while the block is idle; o_cfg_ready is always high.

module quadrature_encoder_button_pulser_unit #(
    parameter int ENCODERS = qebp_pkg::ENCODERS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input transactions
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [qebp_pkg::PIN_W-1:0]      i_pin_a,
    input  wire logic [qebp_pkg::PIN_W-1:0]      i_pin_b,
    input  wire logic [qebp_pkg::PIN_W-1:0]      i_switch_pressed,
    input  wire logic [qebp_pkg::TIME_W-1:0]     i_now_ms,
    // output transactions
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [qebp_pkg::BTN_W-1:0]           o_buttons,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [qebp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [qebp_pkg::CFG_W-1:0]      i_cfg_data
);
    import qebp_pkg::*;

    t_cfg r_cfg;
    logic push;
    logic [LANE_BTNS*ENCODERS-1:0] lane_btn;

    assign push        = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_len <= PULSE_LEN_RST;
            r_cfg.debounce  <= DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PULSE_LEN: r_cfg.pulse_len <= i_cfg_data;
                CFG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // One lane per encoder; encoders past the pin field see all pins low
    for (genvar g = 0; g < ENCODERS; g++) begin : g_lane
        t_lane_in pins;
        if (g < PIN_W) begin : g_pins
            assign pins.pin_a = i_pin_a[g];
            assign pins.pin_b = i_pin_b[g];
            assign pins.sw    = i_switch_pressed[g];
        end else begin : g_none
            assign pins = '0;
        end

        qebp_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (push),
            .i_pins    (pins),
            .i_now     (i_now_ms),
            .i_cfg     (r_cfg),
            .o_buttons (lane_btn[g*LANE_BTNS +: LANE_BTNS])
        );
    end

    // Merge lanes and hold results until taken
    qebp_out_buf #(
        .ENCODERS (ENCODERS)
    ) u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_lane_btn (lane_btn),
        .o_ready    (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_buttons  (o_buttons)
    );

endmodule

`default_nettype wire

/* sv/qebp_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module qebp_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire qebp_pkg::t_lane_in i_pins,
    input  wire logic [qebp_pkg::TIME_W-1:0] i_now,
    input  wire qebp_pkg::t_cfg    i_cfg,
    output logic [qebp_pkg::LANE_BTNS-1:0] o_buttons
);
    import qebp_pkg::*;

    logic [AB_W-1:0]   r_prev_ab, n_prev_ab;
    logic              r_raw_last, n_raw_last;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_change_time, n_change_time;
    logic [1:0]        r_on, n_on;
    logic [TIME_W-1:0] r_rel [2];
    logic [TIME_W-1:0] n_rel [2];

    t_dir              dir;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] elapsed;

    assign n_prev_ab = {i_pins.pin_a, i_pins.pin_b};
    assign dir       = STEP_TABLE[{r_prev_ab, n_prev_ab}];
    assign deadline  = i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.pulse_len};
    assign elapsed   = i_now - r_change_time;

    // Rotation pulses: raise on a step, then drop once the deadline is reached
    always_comb begin
        logic              raised;
        logic              on_m;
        logic [TIME_W-1:0] rel_m;
        logic              expire;
        for (int k = 0; k < 2; k++) begin
            raised = (k == 0) ? (dir == DIR_CW) : (dir == DIR_CCW);
            on_m   = raised | r_on[k];
            rel_m  = raised ? deadline : r_rel[k];
            expire = on_m && (rel_m != '0) && (i_now >= rel_m);
            n_on[k]  = on_m & ~expire;
            n_rel[k] = expire ? '0 : rel_m;
        end
    end

    // Switch debounce
    always_comb begin
        n_raw_last    = r_raw_last;
        n_change_time = r_change_time;
        n_stable      = r_stable;
        if (i_pins.sw != r_raw_last) begin
            n_raw_last    = i_pins.sw;
            n_change_time = i_now;
        end else if (elapsed >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce}
                     && i_pins.sw != r_stable) begin
            n_stable = i_pins.sw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab     <= AB_IDLE;
            r_raw_last    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_on          <= '0;
            r_rel[0]      <= '0;
            r_rel[1]      <= '0;
        end else if (i_en) begin
            r_prev_ab     <= n_prev_ab;
            r_raw_last    <= n_raw_last;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
            r_on          <= n_on;
            r_rel[0]      <= n_rel[0];
            r_rel[1]      <= n_rel[1];
        end
    end

    assign o_buttons = {n_stable, n_on[1], n_on[0]};

endmodule

`default_nettype wire

/* sv/qebp_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module qebp_out_buf #(
    parameter int ENCODERS = qebp_pkg::ENCODERS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    input  wire logic [qebp_pkg::LANE_BTNS*ENCODERS-1:0] i_lane_btn,
    output logic                                       o_ready,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [qebp_pkg::BTN_W-1:0]                 o_buttons
);
    import qebp_pkg::*;

    localparam int ALL_W = LANE_BTNS * ENCODERS;
    localparam int KEEP  = (ALL_W < BTN_W) ? ALL_W : BTN_W;

    logic [BTN_W-1:0] vec;
    logic             r_out_valid, r_skid_valid;
    logic [BTN_W-1:0] r_out_data, r_skid_data;
    logic             pop;

    // Merge lane buttons; drop those above the result field
    always_comb begin
        vec = '0;
        vec[KEEP-1:0] = i_lane_btn[KEEP-1:0];
    end

    assign pop     = r_out_valid & i_ready;
    assign o_ready = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_data <= r_skid_valid ? r_skid_data : vec;
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_data <= vec;
            end else begin
                r_out_data <= vec;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_buttons = r_out_data;

endmodule

`default_nettype wire

/* sim/quadrature_encoder_button_pulser_unit_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the quadrature decoder / switch debounce block.
//
// A short directed table walks every quadrature step in both directions, the
// invalid double-pin jumps, the switch debounce edges and the timestamp wrap
// corners (a deadline that wraps to zero, a deadline that wraps past 2^32).
// Random phases follow, each under its own pulse / debounce setting. Every
// accepted input transaction goes through a local predictor of the block, and
// the vector it predicts, or the row's typed vector, is queued. Each output
// transaction is checked against the head of that queue.

module quadrature_encoder_button_pulser_unit_test;

    import qebp_pkg::*;

    localparam int LANES       = ENCODERS_DEF;
    localparam int BTNS        = LANES * LANE_BTNS;
    localparam int PHASE_ITEMS = 96;
    localparam int SETTLE_CYC  = 4;     // covers the output register, plus margin
    localparam int DRAIN_CYC   = 10;

    // Step direction, indexed by {previous AB, current AB}, A in the upper bit
    localparam t_dir QUAD_STEPS [16] = '{
        DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE,
        DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
        DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
        DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE
    };

    // AB levels in clockwise order; one step forward in this list is one CW step
    localparam logic [AB_W-1:0] GRAY_CW [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    // One row of directed stimulus. When typed is set, buttons holds the
    // expected vector; otherwise the predictor supplies it.
    typedef struct packed {
        logic [PIN_W-1:0]  pin_a;
        logic [PIN_W-1:0]  pin_b;
        logic [PIN_W-1:0]  sw;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        logic [BTN_W-1:0]  buttons;
    } t_probe;

    // All rows run under the reset setting: pulse 20 ms, debounce 8 ms.
    localparam int DIRECTED_ROWS = 24;
    localparam t_probe DIRECTED [DIRECTED_ROWS] = '{
        // idle levels after reset: nothing pressed
        '{5'h1F, 5'h00 | 5'h1F, 5'h00, 32'd0,          1'b1, 15'h0000},
        // 3 -> 2 -> 0 -> 1 -> 3: four CCW steps on every encoder
        '{5'h1F, 5'h00, 5'h00, 32'd100,        1'b1, 15'h2492},
        '{5'h00, 5'h00, 5'h00, 32'd110,        1'b0, 15'h0000},
        '{5'h00, 5'h1F, 5'h00, 32'd125,        1'b0, 15'h0000},
        '{5'h1F, 5'h1F, 5'h00, 32'd140,        1'b0, 15'h0000},
        // every CCW deadline has passed
        '{5'h1F, 5'h1F, 5'h00, 32'd200,        1'b1, 15'h0000},
        // 3 -> 1 -> 0 -> 2 -> 3: four CW steps
        '{5'h00, 5'h1F, 5'h00, 32'd300,        1'b0, 15'h0000},
        '{5'h00, 5'h00, 5'h00, 32'd301,        1'b0, 15'h0000},
        '{5'h1F, 5'h00, 5'h00, 32'd302,        1'b0, 15'h0000},
        '{5'h1F, 5'h1F, 5'h00, 32'd303,        1'b0, 15'h0000},
        // both pins jump: no step, and the CW pulses run out
        '{5'h00, 5'h00, 5'h00, 32'd400,        1'b1, 15'h0000},
        '{5'h1F, 5'h1F, 5'h00, 32'd401,        1'b1, 15'h0000},
        // mixed directions across encoders
        '{5'h15, 5'h0A, 5'h00, 32'd500,        1'b0, 15'h0000},
        // switch press: unstable for 7 ms, accepted at 8 ms
        '{5'h15, 5'h0A, 5'h1F, 32'd1000,       1'b0, 15'h0000},
        '{5'h15, 5'h0A, 5'h1F, 32'd1007,       1'b0, 15'h0000},
        '{5'h15, 5'h0A, 5'h1F, 32'd1008,       1'b1, 15'h4924},
        // bouncing release, then settled released
        '{5'h15, 5'h0A, 5'h0A, 32'd1010,       1'b0, 15'h0000},
        '{5'h15, 5'h0A, 5'h00, 32'd1012,       1'b0, 15'h0000},
        '{5'h15, 5'h0A, 5'h00, 32'd1020,       1'b1, 15'h0000},
        // deadline lands exactly on zero: the pulses never release
        '{5'h1F, 5'h1F, 5'h00, 32'hFFFF_FFEC,  1'b0, 15'h0000},
        '{5'h1F, 5'h1F, 5'h00, 32'hFFFF_FFFF,  1'b0, 15'h0000},
        '{5'h1F, 5'h1F, 5'h00, 32'd5,          1'b0, 15'h0000},
        // deadline wraps past 2^32: released within the same step
        '{5'h00, 5'h1F, 5'h00, 32'hFFFF_FFF0,  1'b0, 15'h0000},
        '{5'h1F, 5'h1F, 5'h1F, 32'hFFFF_FFFF,  1'b0, 15'h0000}
    };

    // Block ports; every input holds a known value from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [PIN_W-1:0]      pin_a = '1;
    logic [PIN_W-1:0]      pin_b = '1;
    logic [PIN_W-1:0]      switch_pressed = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PULSE_LEN;
    logic [CFG_W-1:0]      cfg_data = '0;
    wire                   in_ready;
    wire                   out_valid;
    wire                   cfg_ready;
    wire  [BTN_W-1:0]      buttons;

    // Predictor state: a private copy of the block's registers and lanes
    logic [CFG_W-1:0]      pulse_len_cfg;
    logic [CFG_W-1:0]      debounce_cfg;
    logic [AB_W-1:0]       last_ab [LANES];
    logic                  sw_raw [LANES];
    logic                  sw_level [LANES];
    logic [TIME_W-1:0]     sw_since [LANES];
    logic                  btn_on [BTNS];
    logic [TIME_W-1:0]     btn_deadline [BTNS];

    // Button vectors still owed by the block, oldest first
    logic [BTN_W-1:0]      expected_buttons [$];
    int                    mismatch_count = 0;

    // Random stimulus state
    logic [1:0]            gray_pos [LANES];
    logic [TIME_W-1:0]     stamp_now = '0;
    logic [PIN_W-1:0]      sw_drive = '0;
    bit                    stall_on = 1'b1;
    int                    stall_left = 0;

    quadrature_encoder_button_pulser_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_pin_a          (pin_a),
        .i_pin_b          (pin_b),
        .i_switch_pressed (switch_pressed),
        .i_now_ms         (now_ms),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_buttons        (buttons),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs a handshake
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Drop ready in random bursts while stalling is enabled
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (stall_on && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 2);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Check each output transaction against the oldest expected vector
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_buttons.size() == 0) begin
                $display("%0t: buttons with nothing expected, actual %h", $time, buttons);
                mismatch_count++;
            end else begin
                if (buttons !== expected_buttons[0]) begin
                    $display("%0t: buttons mismatch, expected %h, actual %h",
                             $time, expected_buttons[0], buttons);
                    mismatch_count++;
                end
                expected_buttons.delete(0);
            end
        end
    end

    task automatic clear_predictor();
        pulse_len_cfg = PULSE_LEN_RST;
        debounce_cfg  = DEBOUNCE_RST;
        for (int i = 0; i < LANES; i++) begin
            last_ab[i]  = AB_IDLE;
            sw_raw[i]   = 1'b0;
            sw_level[i] = 1'b0;
            sw_since[i] = '0;
            gray_pos[i] = 2'd2;     // 2'b11 in clockwise order
        end
        for (int k = 0; k < BTNS; k++) begin
            btn_on[k]       = 1'b0;
            btn_deadline[k] = '0;
        end
    endtask

    // Advance the predictor by one sample and return the vector it shows
    function automatic logic [BTN_W-1:0] predict_buttons(
        input logic [PIN_W-1:0]  a,
        input logic [PIN_W-1:0]  b,
        input logic [PIN_W-1:0]  sw,
        input logic [TIME_W-1:0] stamp
    );
        logic [AB_W-1:0]   cur;
        t_dir              step;
        logic [TIME_W-1:0] elapsed;
        logic [BTN_W-1:0]  vec;
        vec = '0;
        for (int i = 0; i < LANES; i++) begin
            cur  = {a[i], b[i]};
            step = QUAD_STEPS[{last_ab[i], cur}];
            if (step == DIR_CW) begin
                btn_on[i*LANE_BTNS]       = 1'b1;
                btn_deadline[i*LANE_BTNS] = stamp + TIME_W'(pulse_len_cfg);
            end else if (step == DIR_CCW) begin
                btn_on[i*LANE_BTNS+1]       = 1'b1;
                btn_deadline[i*LANE_BTNS+1] = stamp + TIME_W'(pulse_len_cfg);
            end
            last_ab[i] = cur;

            // Restart the stability timer on any raw change
            elapsed = stamp - sw_since[i];
            if (sw[i] != sw_raw[i]) begin
                sw_raw[i]   = sw[i];
                sw_since[i] = stamp;
            end else if (elapsed >= TIME_W'(debounce_cfg) && sw[i] != sw_level[i]) begin
                sw_level[i]             = sw[i];
                btn_on[i*LANE_BTNS+2]   = sw[i];
            end
        end
        // Plain unsigned compare; a zero deadline never releases
        for (int k = 0; k < BTNS; k++) begin
            if (btn_on[k] && btn_deadline[k] != '0 && stamp >= btn_deadline[k]) begin
                btn_on[k]       = 1'b0;
                btn_deadline[k] = '0;
            end
        end
        for (int k = 0; k < BTN_W; k++)
            vec[k] = btn_on[k];
        return vec;
    endfunction

    // Present one sample, hold it until the transaction completes, then
    // queue what it should produce
    task automatic drive_sample(
        input logic [PIN_W-1:0]  a,
        input logic [PIN_W-1:0]  b,
        input logic [PIN_W-1:0]  sw,
        input logic [TIME_W-1:0] stamp,
        input logic              typed,
        input logic [BTN_W-1:0]  typed_buttons
    );
        logic [BTN_W-1:0] predicted;
        in_valid       <= 1'b1;
        pin_a          <= a;
        pin_b          <= b;
        switch_pressed <= sw;
        now_ms         <= stamp;
        do @(posedge i_clk); while (!in_ready);
        predicted = predict_buttons(a, b, sw, stamp);
        expected_buttons.push_back(typed ? typed_buttons : predicted);
    endtask

    // Insert a sender gap of random length now and then
    task automatic maybe_gap(input bit idle_on);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_PULSE_LEN: pulse_len_cfg = data;
            CFG_DEBOUNCE:  debounce_cfg  = data;
            default: ;
        endcase
    endtask

    // Drain every outstanding result, let the pipeline settle, then write
    // both registers while the block is idle
    task automatic configure(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] deb);
        in_valid <= 1'b0;
        wait (expected_buttons.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        write_register(CFG_PULSE_LEN, pulse);
        write_register(CFG_DEBOUNCE, deb);
        cfg_valid <= 1'b0;
    endtask

    // Mostly clean rotation with random content; some pin noise, switch
    // toggles and timestamp jumps sized to the current setting
    task automatic run_random(input int count, input bit idle_on);
        logic [PIN_W-1:0] a;
        logic [PIN_W-1:0] b;
        int               span;
        int               r;
        stall_on = idle_on;
        for (int n = 0; n < count; n++) begin
            span = int'(pulse_len_cfg > debounce_cfg ? pulse_len_cfg : debounce_cfg) + 1;
            r = $urandom_range(0, 99);
            if (r < 60)
                stamp_now = stamp_now + $urandom_range(0, 3);
            else if (r < 88)
                stamp_now = stamp_now + $urandom_range(0, 2 * span);
            else if (r < 95)
                stamp_now = $urandom;
            else
                stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * span);

            if ($urandom_range(0, 9) == 0) begin
                // pin noise: any pair, invalid jumps included
                a = PIN_W'($urandom_range(0, 31));
                b = PIN_W'($urandom_range(0, 31));
            end else begin
                for (int i = 0; i < LANES; i++) begin
                    r = $urandom_range(0, 9);
                    if (r >= 4 && r <= 6)
                        gray_pos[i] = gray_pos[i] + 2'd1;
                    else if (r >= 7 && r <= 8)
                        gray_pos[i] = gray_pos[i] - 2'd1;
                    else if (r == 9)
                        gray_pos[i] = 2'($urandom_range(0, 3));
                    a[i] = GRAY_CW[gray_pos[i]][1];
                    b[i] = GRAY_CW[gray_pos[i]][0];
                end
            end

            for (int i = 0; i < LANES; i++)
                if ($urandom_range(0, 7) == 0)
                    sw_drive[i] = ~sw_drive[i];

            drive_sample(a, b, sw_drive, stamp_now, 1'b0, '0);
            maybe_gap(idle_on);
        end
    endtask

    initial begin
        clear_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table under the reset setting
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            drive_sample(DIRECTED[row].pin_a, DIRECTED[row].pin_b, DIRECTED[row].sw,
                         DIRECTED[row].stamp, DIRECTED[row].typed, DIRECTED[row].buttons);
            maybe_gap(1'b1);
        end

        // Zero pulse length and zero debounce
        configure(16'd0, 16'd0);
        run_random(PHASE_ITEMS, 1'b1);
        // Largest setting of both registers
        configure(16'hFFFF, 16'hFFFF);
        run_random(PHASE_ITEMS, 1'b1);
        configure(16'd3, 16'd2);
        run_random(PHASE_ITEMS, 1'b1);
        configure(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(0, 20)));
        run_random(PHASE_ITEMS, 1'b1);
        configure(16'd40, 16'd1);
        run_random(PHASE_ITEMS, 1'b1);
        // Back to the reset setting, with both sides running flat out
        configure(PULSE_LEN_RST, DEBOUNCE_RST);
        run_random(PHASE_ITEMS, 1'b0);

        in_valid <= 1'b0;
        wait (expected_buttons.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
